>>> hw/rtl/bloom_filter_bit_array_macros.svh
// assertion macros for the bloom filter bit array rtl
// no dependencies; included by modules that carry assertions
`ifndef BLOOM_FILTER_BIT_ARRAY_MACROS_SVH
`define BLOOM_FILTER_BIT_ARRAY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfb implication check failed");

// next-cycle implication, disabled while in reset
`define BFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfb next-cycle check failed");

`endif

>>> hw/rtl/bfb_pkg.sv
// shared types, codes and widths for the bloom filter bit array
// no dependencies; imported by every rtl module of the block except bfb_queue
package bfb_pkg;

    localparam int DEFAULT_MAX_BYTES = 4096;

    localparam int BB_W       = 13;
    localparam int WO_W       = 12;
    localparam int HC_W       = 6;
    localparam int HASH_W     = 32;
    localparam int POS_W      = 64;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = POS_W + 2 * HASH_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT    = 2'd2;

    localparam logic [BB_W-1:0] BITMAP_BYTES_RST  = 13'd4096;
    localparam logic [WO_W-1:0] WINDOW_OFFSET_RST = 12'd0;
    localparam logic [HC_W-1:0] HASH_COUNT_RST    = 6'd1;

    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_ADD   = 2'd1,
        JOB_SET   = 2'd2,
        JOB_CHECK = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [2:0]        bit_sel;
        logic              last;
        logic [HASH_W-1:0] first_hash;
        logic [HASH_W-1:0] second_hash;
    } job_t;

endpackage

>>> hw/rtl/bloom_filter_bit_array.sv
// bloom filter bit array top: from acceptance to m_axis_tvalid an add passes the job queue,
// then per probe the remainder unit, a bitmap read and a modify, then the result register;
// set and check skip the remainder unit and other items go straight to the result register
// each add probe is bounded by the one-bit-per-cycle remainder unit (32 steps plus fix-up);
// one item executes at a time and up to two further items wait in the job queue
// after rst_n deasserts the bitmap is swept to zero with s_axis_tready low
module bloom_filter_bit_array #(
    parameter int MAX_BYTES = bfb_pkg::DEFAULT_MAX_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // position [63:0], first_hash [95:64], second_hash [127:96]
    input  logic [bfb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  logic [bfb_pkg::OP_W-1:0]       s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hit [0], zero padding [7:1]
    output logic [bfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfb_pkg::*;

    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int SIZE_W = $clog2(MAX_BYTES + 1);
    localparam int MOD_W  = SIZE_W + 3;
    localparam int SZ_W   = (SIZE_W > BB_W) ? SIZE_W : BB_W;
    localparam int JOB_W  = $bits(job_t);
    localparam int QW     = JOB_W + ADDR_W;

    logic [BB_W-1:0]   bitmap_bytes_reg;
    logic [WO_W-1:0]   window_offset_reg;
    logic [HC_W-1:0]   hash_count_reg;

    logic [SZ_W-1:0]   bb_ext;
    logic [SIZE_W-1:0] size;
    logic [MOD_W-1:0]  modulus;

    job_t              front_job;
    logic [ADDR_W-1:0] front_addr;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [QW-1:0]     q_head;
    job_t              q_job;
    logic [ADDR_W-1:0] q_addr;

    logic              div_start;
    logic [HASH_W-1:0] div_dividend;
    logic              div_done;
    logic [MOD_W-1:0]  div_result;

    logic              clearing;
    logic              out_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_bytes_reg  <= BITMAP_BYTES_RST;
            window_offset_reg <= WINDOW_OFFSET_RST;
            hash_count_reg    <= HASH_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BITMAP_BYTES:  bitmap_bytes_reg  <= cfg_data[BB_W-1:0];
                CFG_WINDOW_OFFSET: window_offset_reg <= cfg_data[WO_W-1:0];
                CFG_HASH_COUNT:    hash_count_reg    <= cfg_data[HC_W-1:0];
                default:           ;
            endcase
        end
    end

    // bytes in use, clamped to the physical store
    always_comb
    begin
        bb_ext  = SZ_W'(bitmap_bytes_reg);
        size    = (bb_ext > SZ_W'(MAX_BYTES)) ? SIZE_W'(MAX_BYTES) : SIZE_W'(bb_ext);
        modulus = {size, 3'b000};
    end

    bfb_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .operation     (s_axis_tuser),
        .position      (s_axis_tdata[POS_W-1:0]),
        .first_hash    (s_axis_tdata[POS_W +: HASH_W]),
        .second_hash   (s_axis_tdata[POS_W+HASH_W +: HASH_W]),
        .last_in_batch (s_axis_tlast),
        .size          (size),
        .window_offset (window_offset_reg),
        .hash_count    (hash_count_reg),
        .job           (front_job),
        .byte_addr     (front_addr)
    );

    assign s_axis_tready = !q_full && !clearing;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    bfb_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_addr, front_job}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign q_job  = job_t'(q_head[JOB_W-1:0]);
    assign q_addr = q_head[QW-1 -: ADDR_W];

    bfb_mod_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .modulus  (modulus),
        .done     (div_done),
        .result   (div_result)
    );

    bfb_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_addr       (q_addr),
        .q_pop        (q_pop),
        .hash_count   (hash_count_reg),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_done     (div_done),
        .div_result   (div_result),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_hit      (out_hit),
        .out_last     (m_axis_tlast),
        .clearing     (clearing)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, out_hit};

endmodule

>>> hw/rtl/bfb_front.sv
// front end: classifies an incoming item into a job and resolves its window address
// depends on bfb_pkg
module bfb_front #(
    parameter int MAX_BYTES = bfb_pkg::DEFAULT_MAX_BYTES,
    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
    localparam int SIZE_W = $clog2(MAX_BYTES + 1)
) (
    input  logic [bfb_pkg::OP_W-1:0]   operation,
    input  logic [bfb_pkg::POS_W-1:0]  position,
    input  logic [bfb_pkg::HASH_W-1:0] first_hash,
    input  logic [bfb_pkg::HASH_W-1:0] second_hash,
    input  logic                       last_in_batch,
    input  logic [SIZE_W-1:0]          size,
    input  logic [bfb_pkg::WO_W-1:0]   window_offset,
    input  logic [bfb_pkg::HC_W-1:0]   hash_count,
    output bfb_pkg::job_t              job,
    output logic [ADDR_W-1:0]          byte_addr
);
    import bfb_pkg::*;

    localparam int CMP_W = ((SIZE_W > WO_W) ? SIZE_W : WO_W) + 1;

    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] off_ext;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] pos_byte;
    logic [CMP_W-1:0] addr_sum;
    logic             off_ok;
    logic             pos_hi_zero;
    logic             in_window;

    always_comb
    begin
        size_ext    = CMP_W'(size);
        off_ext     = CMP_W'(window_offset);
        pos_byte    = CMP_W'(position[3 +: SIZE_W]);
        off_ok      = off_ext < size_ext;
        limit       = size_ext - off_ext;
        // byte index bits above the size range must all be clear
        pos_hi_zero = ~|position[POS_W-1:3+SIZE_W];
        in_window   = off_ok && pos_hi_zero && (pos_byte < limit);
        addr_sum    = off_ext + pos_byte;
        byte_addr   = addr_sum[ADDR_W-1:0];

        job.bit_sel     = position[2:0];
        job.last        = last_in_batch;
        job.first_hash  = first_hash;
        job.second_hash = second_hash;
        unique case (operation)
            OP_ADD:   job.kind = ((size != '0) && (hash_count != '0)) ? JOB_ADD : JOB_NONE;
            OP_SET:   job.kind = in_window ? JOB_SET : JOB_NONE;
            OP_CHECK: job.kind = in_window ? JOB_CHECK : JOB_NONE;
            default:  job.kind = JOB_NONE;
        endcase
    end

endmodule

>>> hw/rtl/bfb_queue.sv
// two-entry job queue between front end and back end
// no package dependencies
module bfb_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] head
);
    localparam int DEPTH = 2;

    logic [W-1:0] entries [DEPTH];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full  = count_reg == 2'(DEPTH);
    assign valid = count_reg != 2'd0;
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/bfb_mod_unit.sv
// bit-serial signed remainder unit: one quotient bit per cycle, then sign fix-up
// depends on bfb_pkg
module bfb_mod_unit #(
    parameter int MAX_BYTES = bfb_pkg::DEFAULT_MAX_BYTES,
    localparam int MOD_W = $clog2(MAX_BYTES + 1) + 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bfb_pkg::HASH_W-1:0] dividend,
    input  logic [MOD_W-1:0]           modulus,
    output logic                       done,
    output logic [MOD_W-1:0]           result
);
    import bfb_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_RUN  = 3'b010,
        MD_FIX  = 3'b100
    } md_state_t;

    md_state_t         state_reg;
    md_state_t         state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [HASH_W-1:0] dvd_reg;
    logic [HASH_W-1:0] dvd_next;
    logic [MOD_W-1:0]  rem_reg;
    logic [MOD_W-1:0]  rem_next;
    logic              neg_reg;
    logic              neg_next;
    logic [MOD_W-1:0]  result_reg;
    logic [MOD_W-1:0]  result_next;

    logic [MOD_W:0]    trial;
    logic [MOD_W:0]    trial_diff;
    logic              trial_ge;

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        result_next = result_reg;

        trial      = {rem_reg, dvd_reg[HASH_W-1]};
        trial_ge   = trial >= {1'b0, modulus};
        trial_diff = trial - {1'b0, modulus};

        unique case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    // work on the magnitude, remember the sign for the fix-up
                    neg_next   = dividend[HASH_W-1];
                    dvd_next   = dividend[HASH_W-1] ? (~dividend + 1'b1) : dividend;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = MD_RUN;
                end
            end
            MD_RUN:
            begin
                rem_next = trial_ge ? trial_diff[MOD_W-1:0] : trial[MOD_W-1:0];
                dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HASH_W - 1))
                begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX:
            begin
                // truncating remainder of a negative value is folded back into range
                result_next = (neg_reg && (rem_reg != '0)) ? (modulus - rem_reg) : rem_reg;
                done_next   = 1'b1;
                state_next  = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

endmodule

>>> hw/rtl/bfb_back.sv
// back end: bitmap memory, clearing sweep, probe sequencing and result register
// depends on bfb_pkg, bfb_mod_unit results and bloom_filter_bit_array_macros.svh
`include "bloom_filter_bit_array_macros.svh"

module bfb_back #(
    parameter int MAX_BYTES = bfb_pkg::DEFAULT_MAX_BYTES,
    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
    localparam int MOD_W = $clog2(MAX_BYTES + 1) + 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  bfb_pkg::job_t              q_job,
    input  logic [ADDR_W-1:0]          q_addr,
    output logic                       q_pop,
    input  logic [bfb_pkg::HC_W-1:0]   hash_count,
    output logic                       div_start,
    output logic [bfb_pkg::HASH_W-1:0] div_dividend,
    input  logic                       div_done,
    input  logic [MOD_W-1:0]           div_result,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_hit,
    output logic                       out_last,
    output logic                       clearing
);
    import bfb_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_READ   = 6'b001000,
        ST_MODIFY = 6'b010000,
        ST_REPLY  = 6'b100000
    } bk_state_t;

    logic [7:0]        mem_bytes [MAX_BYTES];

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [HC_W-1:0]   probe_reg;
    logic [HC_W-1:0]   probe_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_hit_reg;
    logic              out_hit_next;
    logic              out_last_reg;
    logic              out_last_next;

    job_kind_t         kind_reg;
    job_kind_t         kind_next;
    logic [2:0]        bit_reg;
    logic [2:0]        bit_next;
    logic              last_reg;
    logic              last_next;
    logic [HASH_W-1:0] step_reg;
    logic [HASH_W-1:0] step_next;
    logic [HASH_W-1:0] sum_reg;
    logic [HASH_W-1:0] sum_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              hit_reg;
    logic              hit_next;
    logic [7:0]        rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              out_free;
    logic [HC_W-1:0]   probe_inc;
    logic [HASH_W-1:0] sum_step;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_last  = out_last_reg;
    assign clearing  = state_reg == ST_CLEAR;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        probe_next     = probe_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_last_next  = out_last_reg;
        kind_next      = kind_reg;
        bit_next       = bit_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        addr_next      = addr_reg;
        hit_next       = hit_reg;

        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = sum_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = rd_data_reg | (8'd1 << bit_reg);

        out_free  = !out_valid_reg || out_ready;
        probe_inc = probe_reg + 1'b1;
        sum_step  = sum_reg + step_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAX_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_job.kind;
                    bit_next   = q_job.bit_sel;
                    last_next  = q_job.last;
                    step_next  = q_job.second_hash;
                    sum_next   = q_job.first_hash;
                    addr_next  = q_addr;
                    hit_next   = 1'b0;
                    probe_next = '0;
                    unique case (q_job.kind)
                        JOB_ADD:
                        begin
                            div_start    = 1'b1;
                            div_dividend = q_job.first_hash;
                            state_next   = ST_DIV;
                        end
                        JOB_SET, JOB_CHECK:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    addr_next  = div_result[3 +: ADDR_W];
                    bit_next   = div_result[2:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (kind_reg == JOB_CHECK)
                begin
                    hit_next   = rd_data_reg[bit_reg];
                    state_next = ST_REPLY;
                end
                else
                begin
                    mem_we = 1'b1;
                    // next probe of an add reuses the running wrapped sum
                    if ((kind_reg == JOB_ADD) && (probe_inc != hash_count))
                    begin
                        probe_next   = probe_inc;
                        sum_next     = sum_step;
                        div_start    = 1'b1;
                        div_dividend = sum_step;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_REPLY;
                    end
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_last_next  = last_reg;
                    probe_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
        kind_reg     <= kind_next;
        bit_reg      <= bit_next;
        last_reg     <= last_next;
        step_reg     <= step_next;
        sum_reg      <= sum_next;
        addr_reg     <= addr_next;
        hit_reg      <= hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_bytes[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem_bytes[addr_reg];
    end

    `BFB_ASSERT_IMPLY(a_done_only_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `BFB_ASSERT_IMPLY(a_probe_in_range, clk, rst_n, state_reg == ST_DIV, probe_reg < hash_count)
    `BFB_ASSERT_IMPLY(a_no_job_while_clearing, clk, rst_n, state_reg == ST_CLEAR, !q_valid)
    `BFB_ASSERT_IMPLY(a_result_from_reply, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_REPLY))
    `BFB_ASSERT_NEXT(a_single_pop, clk, rst_n, q_pop, state_reg != ST_IDLE)

endmodule

>>> test/tb_bloom_filter_bit_array.sv
// self-checking testbench for bloom_filter_bit_array: directed and random add/set/check
// traffic over several register settings, with results checked against a bit-level predictor
// depends on bfb_pkg and the bloom_filter_bit_array rtl
module tb_bloom_filter_bit_array;
    timeunit 1ns;
    timeprecision 1ps;

    import bfb_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [HASH_W-1:0] first_hash;
        logic [HASH_W-1:0] second_hash;
        logic              last;
    } bloom_item_t;

    typedef struct {
        logic [OUT_DATA_W-1:0] data;
        logic                  last;
    } bloom_answer_t;

    class bitmap_scoreboard;
        logic [7:0]      bitmap [DEFAULT_MAX_BYTES];
        logic [BB_W-1:0] bitmap_bytes;
        logic [WO_W-1:0] window_offset;
        logic [HC_W-1:0] hash_count;
        bloom_answer_t   answers [$];
        int              errors;

        function new();
            foreach (bitmap[i]) bitmap[i] = 8'd0;
            bitmap_bytes  = BITMAP_BYTES_RST;
            window_offset = WINDOW_OFFSET_RST;
            hash_count    = HASH_COUNT_RST;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BITMAP_BYTES:  bitmap_bytes  = data[BB_W-1:0];
                CFG_WINDOW_OFFSET: window_offset = data[WO_W-1:0];
                CFG_HASH_COUNT:    hash_count    = data[HC_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned size_in_use();
            if (bitmap_bytes > DEFAULT_MAX_BYTES)
                return DEFAULT_MAX_BYTES;
            return bitmap_bytes;
        endfunction

        // absolute byte index of a windowed position, 0 when outside the window
        function bit locate(logic [POS_W-1:0] pos, output int unsigned abs_index);
            int unsigned      size;
            logic [POS_W-1:0] b;
            size      = size_in_use();
            b         = pos >> 3;
            abs_index = 0;
            if (window_offset >= size)
                return 1'b0;
            if (b >= 64'(size - window_offset))
                return 1'b0;
            abs_index = window_offset + b[31:0];
            return 1'b1;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [HASH_W-1:0] h1, logic [HASH_W-1:0] h2, logic last);
            bloom_answer_t     ans;
            int unsigned       idx;
            longint            modulus;
            longint            p;
            logic [HASH_W-1:0] sum;
            ans.data = '0;
            ans.last = last;
            case (op)
                OP_ADD:
                begin
                    modulus = longint'(size_in_use()) * 8;
                    if (modulus != 0)
                    begin
                        for (int i = 0; i < hash_count; i++)
                        begin
                            // 32-bit wrapping sum, then truncating remainder fixed up to positive
                            sum = h1 + HASH_W'(i) * h2;
                            p   = longint'($signed(sum)) % modulus;
                            if (p < 0)
                                p += modulus;
                            bitmap[p >> 3][p & 7] = 1'b1;
                        end
                    end
                end
                OP_SET:
                begin
                    if (locate(pos, idx))
                        bitmap[idx][pos[2:0]] = 1'b1;
                end
                OP_CHECK:
                begin
                    if (locate(pos, idx))
                        ans.data[0] = bitmap[idx][pos[2:0]];
                end
                default: ;
            endcase
            answers.push_back(ans);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            bloom_answer_t ans;
            if (answers.size() == 0)
            begin
                $display("%0t unexpected result: tdata %h tlast %b", $time, data, last);
                errors++;
                return;
            end
            ans = answers.pop_front();
            if (data !== ans.data)
            begin
                $display("%0t hit mismatch: expected tdata %h actual %h", $time, ans.data, data);
                errors++;
            end
            if (last !== ans.last)
            begin
                $display("%0t batch_end mismatch: expected %b actual %b", $time, ans.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    bitmap_scoreboard sb = new();
    bit               rx_free = 1'b1;
    int               rx_stall_left = 0;
    logic [POS_W-1:0] recent_sets [$];

    bloom_filter_bit_array uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // monitors: every accepted transaction goes through the scoreboard in edge order
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64],
                         s_axis_tdata[127:96], s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result-side backpressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_free)
                m_axis_tready = 1'b1;
            else if (rx_stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                rx_stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if ($urandom_range(0, 2) == 0)
                    rx_stall_left = gap_len();
            end
        end
    end

    function automatic bloom_item_t make_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                              logic [HASH_W-1:0] h1, logic [HASH_W-1:0] h2,
                                              logic last);
        bloom_item_t it;
        it.op          = op;
        it.pos         = pos;
        it.first_hash  = h1;
        it.second_hash = h2;
        it.last        = last;
        return it;
    endfunction

    // tvalid stays high across back-to-back transactions
    task automatic send_item(bloom_item_t it);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.second_hash, it.first_hash, it.pos};
        s_axis_tuser  = it.op;
        s_axis_tlast  = it.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_tx(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [HASH_W-1:0] random_hash();
        if ($urandom_range(0, 9) < 7)
            return $urandom;
        // small signed values keep probes near both ends of the bitmap
        return HASH_W'($signed($urandom_range(0, 200)) - 100);
    endfunction

    function automatic bloom_item_t random_item();
        bloom_item_t      it;
        int unsigned      size;
        int unsigned      wbytes;
        int               r;
        logic [POS_W-1:0] edge_pos;
        size   = sb.size_in_use();
        wbytes = (size > sb.window_offset) ? size - sb.window_offset : 0;
        r      = $urandom_range(0, 99);
        if (r < 35)
            it.op = OP_ADD;
        else if (r < 60)
            it.op = OP_SET;
        else if (r < 95)
            it.op = OP_CHECK;
        else
            it.op = OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 10)
            it.pos = {$urandom, $urandom};
        else if (r < 22)
        begin
            // straddle the top of the window
            edge_pos = 64'(wbytes) * 8 + 64'($urandom_range(0, 15));
            it.pos   = (edge_pos >= 8) ? edge_pos - 8 : edge_pos;
        end
        else if (wbytes == 0)
            it.pos = 64'($urandom_range(0, 63));
        else
            it.pos = 64'($urandom_range(0, wbytes * 8 - 1));
        if (it.op == OP_CHECK && recent_sets.size() != 0 && $urandom_range(0, 1) == 1)
            it.pos = recent_sets[$urandom_range(0, recent_sets.size() - 1)];
        if (it.op == OP_SET)
        begin
            recent_sets.push_back(it.pos);
            if (recent_sets.size() > 16)
                void'(recent_sets.pop_front());
        end
        it.first_hash  = random_hash();
        it.second_hash = random_hash();
        it.last        = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    task automatic run_phase(logic [CFG_DATA_W-1:0] bb, logic [CFG_DATA_W-1:0] wo,
                             logic [CFG_DATA_W-1:0] hc, int n, bit tx_free, bit rx_mode_free);
        drain();
        repeat (20) @(negedge clk);
        cfg_write(CFG_BITMAP_BYTES, bb);
        cfg_write(CFG_WINDOW_OFFSET, wo);
        cfg_write(CFG_HASH_COUNT, hc);
        recent_sets.delete();
        rx_free = rx_mode_free;
        repeat (n)
        begin
            send_item(random_item());
            if (!tx_free && $urandom_range(0, 1) == 1)
                idle_tx(gap_len());
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 4096 bytes, offset 0, one probe
        rx_free = 1'b0;
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_ADD, 64'd0, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 32'd0, 1'b1));
        send_item(make_item(OP_ADD, 64'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
        send_item(make_item(OP_CHECK, 64'd32767, 32'd0, 32'd0, 1'b1));
        send_item(make_item(OP_ADD, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(OP_ADD, 64'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_item(make_item(OP_SET, 64'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        idle_tx(3);
        send_item(make_item(OP_CHECK, 64'd100, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_CHECK, 64'd101, 32'd0, 32'd0, 1'b0));
        // first position past the bitmap
        send_item(make_item(OP_SET, 64'd32768, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_CHECK, 64'd32768, 32'd0, 32'd0, 1'b1));
        send_item(make_item(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_CHECK, 64'h8000_0000_0000_0000, 32'd0, 32'd0, 1'b0));
        send_item(make_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_CHECK, 64'd32767, 32'd0, 32'd0, 1'b1));

        run_phase(13'd4096, 13'd0, 13'd4, 300, 1'b0, 1'b0);
        drain();
        cfg_write(CFG_UNUSED, 13'($urandom));
        run_phase(13'd64, 13'd8, 13'd3, 250, 1'b1, 1'b0);
        run_phase(13'd1, 13'd0, 13'd2, 150, 1'b0, 1'b1);
        // size above the array, offset at its top
        run_phase(13'd8191, 13'd4095, 13'd5, 100, 1'b0, 1'b0);
        // offset equal to size
        run_phase(13'd16, 13'd16, 13'd2, 80, 1'b1, 1'b1);
        run_phase(13'd0, 13'd0, 13'd3, 60, 1'b0, 1'b0);
        // upper data bits are dropped: offset 100, zero probes
        run_phase(13'h1064, 13'h1064, 13'h1FC0, 100, 1'b0, 1'b0);
        run_phase(13'd200, 13'd3, 13'd32, 40, 1'b0, 1'b0);
        run_phase(13'd33, 13'd0, 13'd63, 10, 1'b0, 1'b0);
        run_phase(13'd2048, 13'd1000, 13'd8, 240, 1'b0, 1'b0);

        drain();
        repeat (200) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #15_000_000;
        $display("%0t timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
